### hdl/lpm_pkg.sv
// ============================================================================
// lpm_pkg - route table package
// Request and response layouts, route record, search token and codes shared
// by the route table top level and its search cells.
// ============================================================================
package lpm_pkg;

   // Address width and the default number of routes held.
   localparam int ADDR_BITS           = 32;
   localparam int DEFAULT_TABLE_DEPTH = 64;

   // Request function codes.
   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // Response status codes.
   localparam logic [1:0] ST_ADDED = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_HIT   = 2'd2;
   localparam logic [1:0] ST_MISS  = 2'd3;

   // One request as it arrives on the input channel.
   typedef struct packed {
      logic                 func;
      logic [ADDR_BITS-1:0] address;
      logic [5:0]           prefix_len;
      logic [ADDR_BITS-1:0] next_hop_in;
      logic [3:0]           iface_in;
      logic [15:0]          metric_in;
      logic [1:0]           protocol_in;
   } req_type;

   // One response as it leaves on the result channel.
   typedef struct packed {
      logic [1:0]           status;
      logic [ADDR_BITS-1:0] match_network;
      logic [5:0]           match_prefix_len;
      logic [ADDR_BITS-1:0] match_next_hop;
      logic [3:0]           match_iface;
      logic [15:0]          match_metric;
      logic [1:0]           match_protocol;
   } rsp_type;

   // One stored route.
   typedef struct packed {
      logic [ADDR_BITS-1:0] network;
      logic [5:0]           prefix;
      logic [ADDR_BITS-1:0] next_hop;
      logic [3:0]           iface;
      logic [15:0]          metric;
      logic [1:0]           protocol;
   } route_type;

   // Search token handed from cell to cell during a lookup.
   typedef struct packed {
      logic                 valid;
      logic [ADDR_BITS-1:0] address;
      logic                 found;
      route_type            route;
   } token_type;

   // Prefix lengths above the address width are stored as a full host route.
   function automatic logic [5:0] sat_prefix(input logic [5:0] len);
      logic [5:0] res;
      res = len;
      if (len > 6'(ADDR_BITS)) begin
         res = 6'(ADDR_BITS);
      end
      return res;
   endfunction

   // Network mask for a prefix length of at most the address width.
   function automatic logic [ADDR_BITS-1:0] mask_of(input logic [5:0] len);
      logic [ADDR_BITS-1:0] ones;
      ones = '1;
      return ~(ones >> len);
   endfunction

endpackage

### hdl/longest_prefix_match_route_table.sv
// ============================================================================
// longest_prefix_match_route_table - IPv4 longest prefix match route table
// Appends routes and answers longest prefix lookups with a chain of cells.
// ============================================================================
// A request is taken at a rising edge with start high and busy low. An add
// request stores its route in the next free cell, or is dropped with status
// full when all TABLE_DEPTH cells are in use; its response appears in the
// next cycle, and adds may follow each other in every cycle unless busy.
// A lookup request sends a search token down the row of cells, one cell per
// cycle, through each cell's token register and then the response register;
// busy stays high until the response is shown, so no new request is taken
// until the lookup in flight has been answered.
// Each response is on rsp_item for exactly one cycle, marked by rsp_valid;
// the receiver cannot stall, so no response is ever held back.
// Reset empties the table (the route count returns to zero) and drops any
// lookup in flight. Stored routes are not cleared and need no clearing pass.
// ============================================================================
module longest_prefix_match_route_table
   import lpm_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             busy_ff;
   logic             busy_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic             accept;
   logic             is_add;
   logic             is_lookup;
   logic             full;
   logic             add_ok;
   route_type        new_route;
   token_type        chain [TABLE_DEPTH+1];
   token_type        exit_tok;

   // Decode the request.
   always_comb begin
      accept    = start && !busy_ff;
      is_add    = accept && (req_item.func == FUNC_ADD);
      is_lookup = accept && (req_item.func == FUNC_LOOKUP);
      full      = count_ff == CNT_W'(TABLE_DEPTH);
      add_ok    = is_add && !full;

      new_route.network  = req_item.address;
      new_route.prefix   = sat_prefix(req_item.prefix_len);
      new_route.next_hop = req_item.next_hop_in;
      new_route.iface    = req_item.iface_in;
      new_route.metric   = req_item.metric_in;
      new_route.protocol = req_item.protocol_in;
   end

   // Inject a fresh search token at the head of the chain.
   always_comb begin
      chain[0]         = '0;
      chain[0].valid   = is_lookup;
      chain[0].address = req_item.address;
   end

   // The row of search cells, one per route slot.
   for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      lpm_cell #(
         .INDEX (gi),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .wr_en       (add_ok && (count_ff == CNT_W'(gi))),
         .wr_route    (new_route),
         .route_count (count_ff),
         .prev_tok    (chain[gi]),
         .next_tok    (chain[gi+1])
      );
   end

   assign exit_tok = chain[TABLE_DEPTH];

   // Next route count, busy flag and response.
   always_comb begin
      count_in = count_ff;
      if (add_ok) begin
         count_in = count_ff + CNT_W'(1);
      end

      busy_in = busy_ff;
      if (is_lookup) begin
         busy_in = 1'b1;
      end else if (exit_tok.valid) begin
         busy_in = 1'b0;
      end

      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      if (is_add) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = full ? ST_FULL : ST_ADDED;
      end else if (exit_tok.valid) begin
         rsp_valid_in = 1'b1;
         if (exit_tok.found) begin
            rsp_in.status           = ST_HIT;
            rsp_in.match_network    = exit_tok.route.network;
            rsp_in.match_prefix_len = exit_tok.route.prefix;
            rsp_in.match_next_hop   = exit_tok.route.next_hop;
            rsp_in.match_iface      = exit_tok.route.iface;
            rsp_in.match_metric     = exit_tok.route.metric;
            rsp_in.match_protocol   = exit_tok.route.protocol;
         end else begin
            rsp_in.status = ST_MISS;
         end
      end
   end

   // Control and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The route count never passes the table depth.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("route count beyond table depth");

   // A token leaving the chain always belongs to a lookup that holds busy.
   a_exit_busy : assert property (@(posedge clock) disable iff (reset)
      exit_tok.valid |-> busy_ff)
      else $error("search token left the chain while idle");

   // An accepted add to a table with room grows the count by one.
   a_add_count : assert property (@(posedge clock) disable iff (reset)
      add_ok |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("route count did not advance on add");

   // An add to a full table is answered with the full status next cycle.
   a_full_rsp : assert property (@(posedge clock) disable iff (reset)
      (is_add && full) |=> (rsp_valid && (rsp_item.status == ST_FULL)))
      else $error("dropped add not reported as full");

   // A hit reports a prefix length no longer than the address.
   a_hit_len : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == ST_HIT)) |->
      (rsp_item.match_prefix_len <= 6'(ADDR_BITS)))
      else $error("hit with an out of range prefix length");

endmodule

### hdl/lpm_cell.sv
// ============================================================================
// lpm_cell - route table search cell
// Holds one route. A passing search token is compared against the route and
// takes it over when the cell is in use and the route matches, with either a
// strictly longer prefix or the token having found nothing yet.
// ============================================================================
module lpm_cell
   import lpm_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  route_type        wr_route,
   input  logic [CNT_W-1:0] route_count,
   input  token_type        prev_tok,
   output token_type        next_tok
);

   route_type            route_ff;
   token_type            tok_ff;
   token_type            tok_in;
   logic                 in_use;
   logic [ADDR_BITS-1:0] mask;
   logic                 hit;
   logic                 take;

   // Store the route when this cell is the next free slot.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_ff <= wr_route;
      end
   end

   // Compare the token against the stored route; earlier cells win on a tie.
   always_comb begin
      in_use = CNT_W'(INDEX) < route_count;
      mask   = mask_of(route_ff.prefix);
      hit    = prev_tok.valid && in_use &&
               ((prev_tok.address & mask) == (route_ff.network & mask));
      take   = hit && (!prev_tok.found || (route_ff.prefix > prev_tok.route.prefix));
      tok_in = prev_tok;
      if (take) begin
         tok_in.found = 1'b1;
         tok_in.route = route_ff;
      end
   end

   // Hand the token on to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign next_tok = tok_ff;

endmodule
